FILE: hdl/itrd_pkg.sv
package itrd_pkg;

	localparam int VALUE_W = 63;
	localparam int BASE_W  = 6;
	localparam int CHAR_W  = 8;
	localparam int DIGIT_W = 6;
	localparam int CHUNK_W = 8;

	localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
	localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(36);

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

	localparam logic [DIGIT_W-1:0] DIGIT_TEN = DIGIT_W'(10);

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		if (d < DIGIT_TEN) begin
			return CHAR_ZERO + CHAR_W'(d);
		end
		return CHAR_A + CHAR_W'(d - DIGIT_TEN);
	endfunction

endpackage

FILE: hdl/itrd_in_if.sv
interface itrd_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [itrd_pkg::VALUE_W-1:0] value;
	logic [itrd_pkg::BASE_W-1:0]       base;

	modport source (output valid, output value, output base, input ready);
	modport sink   (input valid, input value, input base, output ready);
endinterface

FILE: hdl/itrd_out_if.sv
interface itrd_out_if;
	logic                         valid;
	logic                         ready;
	logic [itrd_pkg::CHAR_W-1:0]  character;
	logic                         last;
	logic                         bad_base;

	modport source (output valid, output character, output last, output bad_base, input ready);
	modport sink   (input valid, input character, input last, input bad_base, output ready);
endinterface

FILE: hdl/itrd_div.sv
module itrd_div #(
	parameter int MAG_W = 62
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [MAG_W-1:0]              dividend,
	input  logic [itrd_pkg::DIGIT_W-1:0]  divisor,
	output logic                          done,
	output logic [MAG_W-1:0]              quotient,
	output logic [itrd_pkg::DIGIT_W-1:0]  remainder
);

	localparam int CW    = itrd_pkg::CHUNK_W;
	localparam int DW    = itrd_pkg::DIGIT_W;
	localparam int STEPS = (MAG_W + CW - 1) / CW;
	localparam int PADW  = STEPS * CW;
	localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic [PADW-1:0] sh_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   dvs_q;
	logic [SW-1:0]   step_q;
	logic            busy_q;
	logic            done_q;

	logic [CW-1:0]   qbits;
	logic [DW-1:0]   rem_next;

	// restoring division, one chunk of quotient bits per cycle
	always_comb begin
		logic [DW-1:0] r;
		logic [DW:0]   trial;
		r = rem_q;
		qbits = '0;
		for (int i = 0; i < CW; i++) begin
			trial = {r, sh_q[PADW-1-i]};
			if (trial >= {1'b0, dvs_q}) begin
				qbits[CW-1-i] = 1'b1;
				r = DW'(trial - {1'b0, dvs_q});
			end else begin
				r = trial[DW-1:0];
			end
		end
		rem_next = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == SW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + SW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= PADW'(dividend);
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			sh_q  <= (sh_q << CW) | PADW'(qbits);
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign quotient  = sh_q[MAG_W-1:0];
	assign remainder = rem_q;

endmodule

FILE: hdl/integer_to_radix_digits.sv
// Flow: the number is accepted while idle, then each digit of a nonzero value takes one division in the
// shared divider, then the characters are emitted one per cycle while dout is not stalled.
// Throughput: one transaction at a time; the conversion time of a 62-digit number is
// set by the 8-bit-per-cycle radix divider. Input ready only while idle.
// Reset: arst_n asynchronously clears control state; the digit stack is not reset.
module integer_to_radix_digits #(
	parameter int VALUE_BITS = 63
) (
	input  logic            clk,
	input  logic            arst_n,
	itrd_in_if.sink         din,
	itrd_out_if.source      dout
);

	localparam int MAG_W = VALUE_BITS - 1;
	localparam int DEPTH = VALUE_BITS - 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int DW    = itrd_pkg::DIGIT_W;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 neg_q;
	logic                 bad_q;
	logic [DW-1:0]        base_q;
	logic [DW-1:0]        stk_q [DEPTH];

	logic                 out_valid_q;
	logic [itrd_pkg::CHAR_W-1:0] char_q;
	logic                 last_q;
	logic                 bad_out_q;

	logic [VALUE_BITS-1:0] raw;
	logic [VALUE_BITS-1:0] neg_raw;
	logic                  in_neg;
	logic [MAG_W-1:0]      in_mag;
	logic                  in_bad;
	logic                  in_fire;
	logic                  emit_fire;

	logic                  div_start;
	logic [MAG_W-1:0]      div_dividend;
	logic [DW-1:0]         div_divisor;
	logic                  div_done;
	logic [MAG_W-1:0]      div_quot;
	logic [DW-1:0]         div_rem;

	logic                  push;
	logic                  pop;
	logic [DW-1:0]         push_digit;

	assign raw     = din.value[VALUE_BITS-1:0];
	assign in_neg  = raw[VALUE_BITS-1];
	assign neg_raw = ~raw + VALUE_BITS'(1);
	// most negative value saturates to the largest magnitude
	assign in_mag  = in_neg ? (neg_raw[VALUE_BITS-1] ? '1 : neg_raw[MAG_W-1:0])
	                        : raw[MAG_W-1:0];
	assign in_bad  = (din.base < itrd_pkg::BASE_MIN) || (din.base > itrd_pkg::BASE_MAX);

	assign din.ready = (state_q == S_IDLE);
	assign in_fire   = din.valid && din.ready;
	assign emit_fire = (state_q == S_EMIT) && (!out_valid_q || dout.ready);

	assign div_start    = (in_fire && !in_bad && (in_mag != '0))
	                   || ((state_q == S_DIV) && div_done && (div_quot != '0));
	assign div_dividend = (state_q == S_IDLE) ? in_mag : div_quot;
	assign div_divisor  = (state_q == S_IDLE) ? din.base : base_q;

	itrd_div #(
		.MAG_W(MAG_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	assign push = (in_fire && !in_bad && (in_mag == '0))
	           || ((state_q == S_DIV) && div_done);
	assign push_digit = (state_q == S_IDLE) ? '0 : div_rem;
	assign pop  = emit_fire && !bad_q && !neg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			neg_q       <= 1'b0;
			bad_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end

			if (push) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						bad_q <= in_bad;
						neg_q <= in_neg && !in_bad && (in_mag != '0);
						if (in_bad || (in_mag == '0)) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done && (div_quot == '0)) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_fire) begin
						priority if (bad_q) begin
							bad_q   <= 1'b0;
							state_q <= S_IDLE;
						end else if (neg_q) begin
							neg_q <= 1'b0;
						end else if (cnt_q == CNT_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			base_q <= din.base;
		end
		if (push) begin
			stk_q[0] <= push_digit;
			for (int i = 1; i < DEPTH; i++) begin
				stk_q[i] <= stk_q[i-1];
			end
		end else if (pop) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				stk_q[i] <= stk_q[i+1];
			end
		end
		if (emit_fire) begin
			priority if (bad_q) begin
				char_q    <= itrd_pkg::CHAR_NONE;
				last_q    <= 1'b1;
				bad_out_q <= 1'b1;
			end else if (neg_q) begin
				char_q    <= itrd_pkg::CHAR_MINUS;
				last_q    <= 1'b0;
				bad_out_q <= 1'b0;
			end else begin
				char_q    <= itrd_pkg::digit_char(stk_q[0]);
				last_q    <= (cnt_q == CNT_W'(1));
				bad_out_q <= 1'b0;
			end
		end
	end

	assign dout.valid     = out_valid_q;
	assign dout.character = char_q;
	assign dout.last      = last_q;
	assign dout.bad_base  = bad_out_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("digit stack overflow");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside division phase");

	a_emit_has_text: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_EMIT) && !bad_q) |-> (cnt_q != '0))
		else $error("emit phase with empty digit stack");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> ((cnt_q == '0) && !neg_q && !bad_q))
		else $error("new transaction accepted with leftover text");

endmodule

FILE: tb/integer_to_radix_digits_tb.sv
`timescale 1ns / 1ps
module integer_to_radix_digits_tb;

	localparam int VALUE_W = itrd_pkg::VALUE_W;
	localparam int BASE_W  = itrd_pkg::BASE_W;
	localparam int CHAR_W  = itrd_pkg::CHAR_W;
	localparam int DIGIT_W = itrd_pkg::DIGIT_W;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam logic [VALUE_W-1:0] MAX_POS  = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};
	localparam logic [VALUE_W-1:0] MINUS_ONE = {VALUE_W{1'b1}};

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
		logic              bad_base;
	} text_char_t;

	class radix_text_checker;
		text_char_t pending_chars[$];
		int errors = 0;
		int numbers = 0;
		int chars_checked = 0;
		int bad_radix = 0;
		int longest = 0;

		function void note_number(logic [VALUE_W-1:0] value, logic [BASE_W-1:0] base);
			string alphabet;
			logic [VALUE_W-1:0] mag;
			logic negative;
			logic [DIGIT_W-1:0] digits[$];
			alphabet = "0123456789abcdefghijklmnopqrstuvwxyz";
			numbers++;
			if (base < itrd_pkg::BASE_MIN || base > itrd_pkg::BASE_MAX) begin
				bad_radix++;
				pending_chars.push_back('{itrd_pkg::CHAR_NONE, 1'b1, 1'b1});
				return;
			end
			negative = value[VALUE_W-1];
			mag = negative ? -value : value;
			// most negative value saturates
			if (mag[VALUE_W-1]) begin
				mag = MAX_POS;
			end
			if (mag == '0) begin
				digits.push_back('0);
			end
			while (mag != '0) begin
				digits.push_front(DIGIT_W'(mag % base));
				mag = mag / base;
			end
			if (negative) begin
				pending_chars.push_back('{itrd_pkg::CHAR_MINUS, 1'b0, 1'b0});
			end
			foreach (digits[i]) begin
				pending_chars.push_back('{CHAR_W'(alphabet[digits[i]]),
					i == digits.size() - 1, 1'b0});
			end
			if (digits.size() + negative > longest) begin
				longest = digits.size() + negative;
			end
		endfunction

		function void check_char(text_char_t got);
			text_char_t want;
			if (pending_chars.size() == 0) begin
				$error("unexpected transaction: character %h last %b bad_base %b",
					got.character, got.last, got.bad_base);
				errors++;
				return;
			end
			want = pending_chars.pop_front();
			chars_checked++;
			if (got.character !== want.character) begin
				$error("character: expected %h, got %h", want.character, got.character);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %b, got %b", want.last, got.last);
				errors++;
			end
			if (got.bad_base !== want.bad_base) begin
				$error("bad_base: expected %b, got %b", want.bad_base, got.bad_base);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   src_idle_pct = 0;
	int   sink_stall_pct = 0;
	int   idle_cycles;

	radix_text_checker radix_text = new();

	itrd_in_if  din_if();
	itrd_out_if dout_if();

	integer_to_radix_digits u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_number(input logic [VALUE_W-1:0] value, input logic [BASE_W-1:0] base);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			din_if.valid <= 1'b0;
			@(posedge clk);
		end
		din_if.valid <= 1'b1;
		din_if.value <= value;
		din_if.base  <= base;
		@(posedge clk);
		while (!din_if.ready) begin
			@(posedge clk);
		end
		radix_text.note_number(value, base);
	endtask

	function automatic logic [VALUE_W-1:0] random_value();
		logic [63:0] raw;
		logic [VALUE_W-1:0] v;
		int width;
		int kind;
		raw = {$urandom(), $urandom()};
		width = $urandom_range(1, VALUE_W - 1);
		kind = $urandom_range(0, 3);
		unique case (kind)
			0: begin
				v = raw[VALUE_W-1:0];
			end
			1: begin
				v = VALUE_W'($urandom_range(0, 1000));
			end
			2: begin
				v = raw[VALUE_W-1:0] & VALUE_W'((64'd1 << width) - 64'd1);
			end
			default: begin
				unique case (raw[1:0])
					2'd0: v = MAX_POS;
					2'd1: v = MOST_NEG;
					2'd2: v = MINUS_ONE;
					default: v = '0;
				endcase
			end
		endcase
		if (kind != 0 && $urandom_range(0, 1) == 1) begin
			v = -v;
		end
		return v;
	endfunction

	function automatic logic [BASE_W-1:0] random_base();
		if ($urandom_range(0, 99) < 12) begin
			return BASE_W'($urandom_range(0, 63));
		end
		return BASE_W'($urandom_range(2, 36));
	endfunction

	// result side: check and random stall
	initial begin
		dout_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && dout_if.valid && dout_if.ready) begin
				radix_text.check_char('{dout_if.character, dout_if.last, dout_if.bad_base});
			end
			dout_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		din_if.valid <= 1'b0;
		din_if.value <= '0;
		din_if.base  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		send_number('0, BASE_W'(10));
		send_number('0, BASE_W'(2));
		send_number('0, BASE_W'(0));
		send_number(VALUE_W'(12345), BASE_W'(0));
		send_number(VALUE_W'(7), BASE_W'(1));
		send_number(-VALUE_W'(99), BASE_W'(37));
		send_number(MAX_POS, BASE_W'(63));
		send_number(MAX_POS, itrd_pkg::BASE_MIN);
		send_number(MAX_POS, itrd_pkg::BASE_MAX);
		send_number(MAX_POS, BASE_W'(10));
		send_number(-MAX_POS, itrd_pkg::BASE_MIN);
		send_number(MOST_NEG, itrd_pkg::BASE_MIN);
		send_number(MOST_NEG, BASE_W'(16));
		send_number(MINUS_ONE, itrd_pkg::BASE_MIN);
		send_number(VALUE_W'(1), itrd_pkg::BASE_MAX);
		send_number(VALUE_W'(35), itrd_pkg::BASE_MAX);
		send_number(VALUE_W'(36), itrd_pkg::BASE_MAX);
		send_number(VALUE_W'(10), BASE_W'(11));
		send_number(VALUE_W'(9), BASE_W'(10));
		send_number(-VALUE_W'(255), BASE_W'(8));
		send_number(VALUE_W'(80), BASE_W'(3));

		for (int phase = 0; phase < 4; phase++) begin
			unique case (phase)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 47; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 47; end
				default: begin src_idle_pct = 12; sink_stall_pct = 12; end
			endcase
			repeat (35) send_number(random_value(), random_base());
		end
		din_if.valid <= 1'b0;

		while (radix_text.pending_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);

		$display("%0d numbers converted (%0d with a bad radix), %0d characters checked,",
			radix_text.numbers, radix_text.bad_radix, radix_text.chars_checked);
		$display("longest text %0d characters; idling none, sender, receiver, both",
			radix_text.longest);
		if (radix_text.errors == 0 && radix_text.pending_chars.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hdl/itrd_pkg.sv
hdl/itrd_in_if.sv
hdl/itrd_out_if.sv
hdl/itrd_div.sv
hdl/integer_to_radix_digits.sv
tb/integer_to_radix_digits_tb.sv
